FILE: sv/utf8cs_pkg.sv
// Shared types, constants and control store for the UTF-8 cell splitter.
`timescale 1ns / 1ps
package utf8cs_pkg;

	localparam logic [7:0] LEAD2_LO  = 8'hC2;
	localparam logic [7:0] LEAD2_HI  = 8'hDF;
	localparam logic [7:0] LEAD3_LO  = 8'hE0;
	localparam logic [7:0] LEAD3_HI  = 8'hEF;
	localparam logic [7:0] LEAD4_LO  = 8'hF0;
	localparam logic [7:0] LEAD4_HI  = 8'hF4;
	localparam logic [7:0] CONT_MASK = 8'hC0;
	localparam logic [7:0] CONT_TAG  = 8'h80;
	localparam logic [7:0] LEAD_SURR = 8'hED;
	localparam logic [7:0] MIN3_2ND  = 8'hA0;
	localparam logic [7:0] MAX_SURR  = 8'h9F;
	localparam logic [7:0] MIN4_2ND  = 8'h90;
	localparam logic [7:0] MAX4_2ND  = 8'h8F;

	typedef logic step_t;
	localparam step_t STEP_TAKE  = 1'b0;
	localparam step_t STEP_PARSE = 1'b1;

	typedef enum logic {
		COND_IN_XFER,
		COND_OP_DONE
	} cond_t;

	typedef struct packed {
		logic  take;
		logic  parse;
		cond_t cond;
		step_t on_true;
		step_t on_false;
	} uword_t;

	typedef struct packed {
		logic [31:0] bytes;
		logic [2:0]  size;
		logic [20:0] cp;
		logic        seq;
	} cell_t;

	typedef struct packed {
		logic take;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic  emits;
		logic  done_after;
		cell_t res;
	} dp_stat_t;

	function automatic uword_t ucode_rom(step_t s);
		uword_t w;
		case (s)
			STEP_TAKE: w = '{take: 1'b1, parse: 1'b0, cond: COND_IN_XFER,
				on_true: STEP_PARSE, on_false: STEP_TAKE};
			STEP_PARSE: w = '{take: 1'b0, parse: 1'b1, cond: COND_OP_DONE,
				on_true: STEP_TAKE, on_false: STEP_PARSE};
			default: w = '{take: 1'b1, parse: 1'b0, cond: COND_IN_XFER,
				on_true: STEP_PARSE, on_false: STEP_TAKE};
		endcase
		return w;
	endfunction

	function automatic logic [2:0] lead_len(logic [7:0] b);
		logic [2:0] n;
		if (b >= LEAD2_LO && b <= LEAD2_HI)
			n = 3'd2;
		else if (b >= LEAD3_LO && b <= LEAD3_HI)
			n = 3'd3;
		else if (b >= LEAD4_LO && b <= LEAD4_HI)
			n = 3'd4;
		else
			n = 3'd0;
		return n;
	endfunction

endpackage

FILE: sv/utf8cs_datapath.sv
// Byte window, sequence parser and cell builder driven by the control store.
`timescale 1ns / 1ps
module utf8cs_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  utf8cs_pkg::dp_cmd_t cmd,
	input  logic [7:0]          in_byte,
	input  logic                end_of_string,
	input  logic                lenient,
	output utf8cs_pkg::dp_stat_t stat
);
	import utf8cs_pkg::*;

	// window: first cnt bytes are the open sequence, the rest are unparsed
	logic [7:0] w_q [4];
	logic [2:0] len_q, cnt_q, exp_q;
	logic       bad_q, eos_q;

	logic [7:0] b;
	logic       have, flush, bad_n, ok;
	logic [2:0] lead, cnt_inc, shift;
	logic [2:0] len_n, cnt_n, exp_n;
	logic       bad_nx;
	logic [7:0] w_sh [4];
	logic [2:0] idx [4];
	logic [20:0] cp_seq;
	logic [31:0] bytes_seq;
	cell_t      res_d;
	logic       emits;

	always_comb begin
		b       = w_q[cnt_q[1:0]];
		have    = cnt_q < len_q;
		flush   = !have && eos_q && (cnt_q != 3'd0);
		lead    = lead_len(b);
		cnt_inc = cnt_q + 3'd1;
		bad_n   = bad_q | ((b & CONT_MASK) != CONT_TAG);

		ok = !bad_n;
		if (exp_q == 3'd3) begin
			if (w_q[0] == LEAD3_LO && w_q[1] < MIN3_2ND)
				ok = 1'b0;
			if (w_q[0] == LEAD_SURR && w_q[1] > MAX_SURR)
				ok = 1'b0;
		end else if (exp_q == 3'd4) begin
			if (w_q[0] == LEAD4_LO && w_q[1] < MIN4_2ND)
				ok = 1'b0;
			if (w_q[0] == LEAD4_HI && w_q[1] > MAX4_2ND)
				ok = 1'b0;
		end

		case (cnt_inc)
			3'd2: begin
				cp_seq    = {10'd0, w_q[0][4:0], w_q[1][5:0]};
				bytes_seq = {16'd0, w_q[1], w_q[0]};
			end
			3'd3: begin
				cp_seq    = {5'd0, w_q[0][3:0], w_q[1][5:0], w_q[2][5:0]};
				bytes_seq = {8'd0, w_q[2], w_q[1], w_q[0]};
			end
			default: begin
				cp_seq    = {w_q[0][2:0], w_q[1][5:0], w_q[2][5:0], w_q[3][5:0]};
				bytes_seq = {w_q[3], w_q[2], w_q[1], w_q[0]};
			end
		endcase

		emits  = 1'b0;
		res_d  = '{bytes: {24'd0, w_q[0]}, size: 3'd1, cp: {13'd0, w_q[0]}, seq: 1'b0};
		shift  = 3'd0;
		cnt_n  = cnt_q;
		exp_n  = exp_q;
		bad_nx = bad_q;

		if (have && cnt_q == 3'd0) begin
			if (lead == 3'd0) begin
				emits = 1'b1;
				shift = 3'd1;
			end else begin
				cnt_n  = 3'd1;
				exp_n  = lead;
				bad_nx = 1'b0;
			end
		end else if (have) begin
			if (cnt_inc >= exp_q) begin
				emits  = 1'b1;
				cnt_n  = 3'd0;
				bad_nx = 1'b0;
				if (lenient || ok) begin
					res_d = '{bytes: bytes_seq, size: cnt_inc, cp: cp_seq, seq: 1'b1};
					shift = cnt_inc;
				end else begin
					shift = 3'd1;
				end
			end else begin
				cnt_n  = cnt_inc;
				bad_nx = bad_n;
			end
		end else if (flush) begin
			emits  = 1'b1;
			shift  = 3'd1;
			cnt_n  = 3'd0;
			bad_nx = 1'b0;
		end

		len_n = len_q - shift;
		for (int i = 0; i < 4; i++) begin
			idx[i]  = 3'(i) + shift;
			w_sh[i] = (idx[i] < 3'd4) ? w_q[idx[i][1:0]] : 8'd0;
		end

		stat.emits      = emits;
		stat.done_after = !((cnt_n < len_n) || (eos_q && cnt_n != 3'd0));
		stat.res        = res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= 3'd0;
			cnt_q <= 3'd0;
			exp_q <= 3'd0;
			bad_q <= 1'b0;
			eos_q <= 1'b0;
		end else if (cmd.take) begin
			len_q <= len_q + 3'd1;
			eos_q <= end_of_string;
		end else if (cmd.commit) begin
			len_q <= len_n;
			cnt_q <= cnt_n;
			exp_q <= exp_n;
			bad_q <= bad_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take)
			w_q[len_q[1:0]] <= in_byte;
		else if (cmd.commit)
			w_q <= w_sh;
	end

endmodule

FILE: sv/utf8_stream_cell_splitter_unit.sv
// Top level: control-store sequencer, result hold stage and output register.
`timescale 1ns / 1ps
// Splits a UTF-8 byte stream into character cells. Each input byte is first
// accepted in the take step and then goes through parse steps. A rejected
// sequence emits its lead byte and sends the other buffered bytes through the
// parser again, one step each, and those can be rejected in turn; an
// end_of_string byte flushes whatever is still open the same way. A byte needs
// at most seven parse steps without end_of_string and at most ten with it,
// plus any cycles the output stalls.
// The cells from one byte leave in order; the last one carries last_of_run.
// The lenient_mode write channel is always ready and is meant to be written
// while no byte is in flight.
module utf8_stream_cell_splitter_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        end_of_string,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        lenient_mode,
	output logic        cell_valid,
	input  logic        cell_stall,
	output logic [31:0] cell_bytes,
	output logic [2:0]  cell_size,
	output logic [20:0] code_point,
	output logic        is_sequence,
	output logic        last_of_run
);
	import utf8cs_pkg::*;

	step_t    step_q, step_d;
	uword_t   uw;
	dp_cmd_t  cmd;
	dp_stat_t st;
	logic     lenient_q;
	logic     in_xfer, out_free, emit_go, hold_move, cond;
	logic     hold_v_q, hold_last_q, out_v_q, out_last_q;
	cell_t    hold_cell_q, out_cell_q;

	assign uw        = ucode_rom(step_q);
	assign in_stall  = !uw.take;
	assign in_xfer   = in_valid && uw.take;
	assign cfg_ready = 1'b1;

	assign out_free   = !out_v_q || !cell_stall;
	assign cmd.take   = in_xfer;
	assign cmd.commit = uw.parse && (!st.emits || !hold_v_q || out_free);
	assign emit_go    = cmd.commit && st.emits;
	assign hold_move  = hold_v_q && out_free && (hold_last_q || emit_go);

	always_comb begin
		case (uw.cond)
			COND_IN_XFER: cond = in_xfer;
			COND_OP_DONE: cond = cmd.commit && st.done_after;
			default:      cond = 1'b0;
		endcase
		step_d = cond ? uw.on_true : uw.on_false;
	end

	utf8cs_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.in_byte       (in_byte),
		.end_of_string (end_of_string),
		.lenient       (lenient_q),
		.stat          (st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= STEP_TAKE;
			lenient_q   <= 1'b0;
			hold_v_q    <= 1'b0;
			hold_last_q <= 1'b0;
			out_v_q     <= 1'b0;
		end else begin
			step_q <= step_d;
			if (cfg_valid && cfg_ready)
				lenient_q <= lenient_mode;
			if (emit_go) begin
				hold_v_q    <= 1'b1;
				hold_last_q <= st.done_after;
			end else if (hold_move) begin
				hold_v_q <= 1'b0;
			end else if (cmd.commit && st.done_after) begin
				hold_last_q <= 1'b1;
			end
			if (hold_move)
				out_v_q <= 1'b1;
			else if (!cell_stall)
				out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go)
			hold_cell_q <= st.res;
		if (hold_move) begin
			out_cell_q <= hold_cell_q;
			out_last_q <= hold_last_q;
		end
	end

	assign cell_valid  = out_v_q;
	assign cell_bytes  = out_cell_q.bytes;
	assign cell_size   = out_cell_q.size;
	assign code_point  = out_cell_q.cp;
	assign is_sequence = out_cell_q.seq;
	assign last_of_run = out_last_q;

endmodule
